FILE: rtl/core/cbpm_pkg.sv
// Shared types and codes of the clock buffer pool manager.
`timescale 1ns / 1ps
`default_nettype none
package cbpm_pkg;

    typedef enum logic [2:0] {
        CMD_PIN     = 3'd0,
        CMD_UNPIN   = 3'd1,
        CMD_INSTALL = 3'd2,
        CMD_DISPOSE = 3'd3,
        CMD_FLUSH   = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FRAME  = 3'd1,
        ST_NOT_RES   = 3'd2,
        ST_NOT_PIN   = 3'd3,
        ST_PINNED    = 3'd4,
        ST_RESIDENT  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_ALIGN,
        S_SCAN,
        S_FLUSH,
        S_EMIT
    } state_t;

    localparam logic [7:0] PIN_MAX = 8'hFF;

    typedef struct packed {
        logic [7:0]  tag_file;
        logic [19:0] tag_page;
        logic        valid;
        logic        refbit;
        logic        dirty;
        logic [7:0]  pin;
    } frame_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  frame;
        logic        hit;
        logic        fetch;
        logic        writeback;
        logic [7:0]  wb_file;
        logic [19:0] wb_page;
        logic        last;
    } rsp_t;

endpackage
`default_nettype wire

FILE: rtl/core/cbpm_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface cbpm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [7:0]  file_id;
    logic [19:0] page_no;
    logic        mark_dirty;
    modport source (output valid, command, file_id, page_no, mark_dirty, input ready);
    modport sink (input valid, command, file_id, page_no, mark_dirty, output ready);
endinterface

interface cbpm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  frame;
    logic        hit;
    logic        fetch;
    logic        writeback;
    logic [7:0]  wb_file;
    logic [19:0] wb_page;
    logic        last;
    modport source (output valid, status, frame, hit, fetch, writeback, wb_file, wb_page,
                    last, input ready);
    modport sink (input valid, status, frame, hit, fetch, writeback, wb_file, wb_page,
                  last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/clock_buffer_pool_manager.sv
// A hit or simple command looks up every frame, then responds; a miss on a pin or install
// also rotates the ring to the clock hand and scans from there for a victim; a flush
// rotates the ring to frame 0 and scans it for the file's frames, then emits its results.
// One command at a time; the ring of frame cells rotates one frame per cycle while it shifts.
// Reset: all frames invalid and cleared, clock hand on the last frame, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module clock_buffer_pool_manager
    import cbpm_pkg::*;
#(
    parameter int NUM_FRAMES = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cbpm_req_if.sink    req,
    cbpm_rsp_if.source  rsp
);

    localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = $clog2(2 * NUM_FRAMES + 1);

    logic [IW-1:0] cell_idx [NUM_FRAMES];
    frame_t        cell_data [NUM_FRAMES];

    logic          shift_en;
    logic          head_wr;
    frame_t        head_new;

    state_t        state_reg, state_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic [7:0]    file_reg, file_next;
    logic [19:0]   page_reg, page_next;
    logic          md_reg, md_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          found_reg, found_next;
    logic [IW-1:0] hand_reg, hand_next;
    rsp_t          res_reg, res_next;
    rsp_t          out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic          accept;
    logic          can_emit;
    logic          head_match;
    logic          file_match;
    logic          search_end;
    logic          scan_end;
    logic          flush_end;
    logic [IW-1:0] align_tgt;
    frame_t        head;
    frame_t        fresh;

    genvar g;
    generate
        for (g = 0; g < NUM_FRAMES; g++)
        begin : g_cell
            if (g == NUM_FRAMES - 1)
            begin : g_tail
                cbpm_cell #(.IW(IW), .POS(g)) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .shift      (shift_en),
                    .write      (1'b0),
                    .shift_idx  (cell_idx[0]),
                    .shift_data (head_new),
                    .write_data (head_new),
                    .idx        (cell_idx[g]),
                    .data       (cell_data[g])
                );
            end
            else if (g == 0)
            begin : g_head
                cbpm_cell #(.IW(IW), .POS(g)) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .shift      (shift_en),
                    .write      (head_wr),
                    .shift_idx  (cell_idx[g+1]),
                    .shift_data (cell_data[g+1]),
                    .write_data (head_new),
                    .idx        (cell_idx[g]),
                    .data       (cell_data[g])
                );
            end
            else
            begin : g_mid
                cbpm_cell #(.IW(IW), .POS(g)) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .shift      (shift_en),
                    .write      (1'b0),
                    .shift_idx  (cell_idx[g+1]),
                    .shift_data (cell_data[g+1]),
                    .write_data (head_new),
                    .idx        (cell_idx[g]),
                    .data       (cell_data[g])
                );
            end
        end
    endgenerate

    assign head       = cell_data[0];
    assign accept     = req.valid && req.ready;
    assign can_emit   = !out_valid_reg || rsp.ready;
    assign file_match = head.valid && (head.tag_file == file_reg);
    assign head_match = file_match && (head.tag_page == page_reg);
    assign search_end = (cnt_reg == CW'(NUM_FRAMES - 1));
    assign scan_end   = (cnt_reg == CW'(2 * NUM_FRAMES));
    assign flush_end  = (cnt_reg == CW'(NUM_FRAMES));
    assign align_tgt  = (cmd_reg == CMD_FLUSH) ? '0 : hand_reg;

    always_comb
    begin
        fresh          = '0;
        fresh.tag_file = file_reg;
        fresh.tag_page = page_reg;
        fresh.valid    = 1'b1;
        fresh.refbit   = 1'b1;
        fresh.pin      = 8'd1;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.command inside {CMD_PIN, CMD_UNPIN, CMD_INSTALL, CMD_DISPOSE})
                        state_next = S_SEARCH;
                    else if (req.command == CMD_FLUSH)
                        state_next = S_ALIGN;
                end
            end
            S_SEARCH:
            begin
                if (search_end)
                begin
                    if (found_reg || head_match)
                        state_next = S_EMIT;
                    else if (cmd_reg == CMD_PIN || cmd_reg == CMD_INSTALL)
                        state_next = S_ALIGN;
                    else
                        state_next = S_EMIT;
                end
            end
            S_ALIGN:
            begin
                if (cell_idx[0] == align_tgt)
                    state_next = (cmd_reg == CMD_FLUSH) ? S_FLUSH : S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_end || !head.valid || (!head.refbit && head.pin == '0))
                    state_next = S_EMIT;
            end
            S_FLUSH:
            begin
                if (flush_end || (file_match && head.pin != '0))
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (can_emit)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cmd_next       = cmd_reg;
        file_next      = file_reg;
        page_next      = page_reg;
        md_next        = md_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        hand_next      = hand_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = rsp.ready ? 1'b0 : out_valid_reg;
        shift_en       = 1'b0;
        head_wr        = 1'b0;
        head_new       = head;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = req.command;
                    file_next  = req.file_id;
                    page_next  = req.page_no;
                    md_next    = req.mark_dirty;
                    cnt_next   = '0;
                    found_next = 1'b0;
                end
            end
            S_SEARCH:
            begin
                shift_en = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (head_match)
                begin
                    found_next     = 1'b1;
                    res_next       = '0;
                    res_next.frame = 4'(cell_idx[0]);
                    res_next.hit   = 1'b1;
                    res_next.last  = 1'b1;
                    case (cmd_reg)
                        CMD_PIN:
                        begin
                            head_new.refbit = 1'b1;
                            if (head.pin != PIN_MAX)
                                head_new.pin = head.pin + 1'b1;
                        end
                        CMD_UNPIN:
                        begin
                            if (head.pin == '0)
                                res_next.status = ST_NOT_PIN;
                            else
                            begin
                                head_new.pin   = head.pin - 1'b1;
                                head_new.dirty = head.dirty | md_reg;
                            end
                        end
                        CMD_INSTALL: res_next.status = ST_RESIDENT;
                        CMD_DISPOSE: head_new = '0;
                        default: res_next.status = ST_OK;
                    endcase
                end
                else if (search_end && !found_reg)
                begin
                    res_next      = '0;
                    res_next.last = 1'b1;
                    if (cmd_reg == CMD_UNPIN)
                        res_next.status = ST_NOT_RES;
                end
                if (search_end)
                    cnt_next = '0;
            end
            S_ALIGN:
            begin
                if (cell_idx[0] != align_tgt)
                    shift_en = 1'b1;
            end
            S_SCAN:
            begin
                res_next      = '0;
                res_next.last = 1'b1;
                res_next.frame = 4'(cell_idx[0]);
                res_next.fetch = (cmd_reg == CMD_PIN);
                if (scan_end)
                begin
                    res_next.status = ST_NO_FRAME;
                    res_next.frame  = '0;
                    res_next.fetch  = 1'b0;
                    hand_next       = cell_idx[0];
                end
                else if (!head.valid)
                begin
                    // take the free frame and step past it
                    head_new  = fresh;
                    shift_en  = 1'b1;
                    hand_next = cell_idx[1];
                end
                else if (head.refbit)
                begin
                    head_new.refbit = 1'b0;
                    shift_en        = 1'b1;
                    cnt_next        = cnt_reg + 1'b1;
                end
                else if (head.pin == '0)
                begin
                    // evict; hand stays on the victim
                    res_next.writeback = head.dirty;
                    res_next.wb_file   = head.dirty ? head.tag_file : '0;
                    res_next.wb_page   = head.dirty ? head.tag_page : '0;
                    head_new           = fresh;
                    head_wr            = 1'b1;
                    hand_next          = cell_idx[0];
                end
                else
                begin
                    shift_en = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FLUSH:
            begin
                res_next      = '0;
                res_next.last = 1'b1;
                if (flush_end)
                    res_next.status = ST_OK;
                else if (file_match && head.pin != '0)
                begin
                    res_next.status = ST_PINNED;
                    res_next.frame  = 4'(cell_idx[0]);
                end
                else if (file_match && head.dirty)
                begin
                    // hold until the output slot frees up
                    if (can_emit)
                    begin
                        out_next           = '0;
                        out_next.frame     = 4'(cell_idx[0]);
                        out_next.writeback = 1'b1;
                        out_next.wb_file   = head.tag_file;
                        out_next.wb_page   = head.tag_page;
                        out_valid_next     = 1'b1;
                        head_new           = '0;
                        shift_en           = 1'b1;
                        cnt_next           = cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    if (file_match)
                        head_new = '0;
                    shift_en = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (can_emit)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            hand_reg      <= IW'(NUM_FRAMES - 1);
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hand_reg      <= hand_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        file_reg <= file_next;
        page_reg <= page_next;
        md_reg   <= md_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_reg.status;
    assign rsp.frame     = out_reg.frame;
    assign rsp.hit       = out_reg.hit;
    assign rsp.fetch     = out_reg.fetch;
    assign rsp.writeback = out_reg.writeback;
    assign rsp.wb_file   = out_reg.wb_file;
    assign rsp.wb_page   = out_reg.wb_page;
    assign rsp.last      = out_reg.last;

endmodule
`default_nettype wire

FILE: rtl/core/cbpm_cell.sv
// One frame cell of the rotating frame ring.
`timescale 1ns / 1ps
`default_nettype none
module cbpm_cell
    import cbpm_pkg::*;
#(
    parameter int IW  = 4,
    parameter int POS = 0
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          shift,
    input  wire logic          write,
    input  wire logic [IW-1:0] shift_idx,
    input  wire frame_t        shift_data,
    input  wire frame_t        write_data,
    output logic      [IW-1:0] idx,
    output frame_t             data
);

    logic [IW-1:0] idx_reg;
    frame_t        data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= IW'(POS);
            data_reg <= '0;
        end
        else if (shift)
        begin
            idx_reg  <= shift_idx;
            data_reg <= shift_data;
        end
        else if (write)
        begin
            data_reg <= write_data;
        end
    end

    assign idx  = idx_reg;
    assign data = data_reg;

endmodule
`default_nettype wire
